// ----- hdl/homogeneous_point_transform_assert.svh -----
// assertion macros for the point transform modules, used by the queue
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hpt assertion failed");

// next-cycle implication, checked out of reset
`define HPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hpt assertion failed");

`endif

// ----- hdl/hpt_pkg.sv -----
package hpt_pkg;

    localparam int HPT_FIFO_DEPTH = 4;
    localparam int HPT_QBITS      = 17;
    localparam int HPT_ACC_W      = 34;
    localparam int HPT_MAG_W      = 33;
    localparam int HPT_NUM_W      = 41;
    localparam int HPT_CMP_W      = 50;

    localparam logic signed [15:0] HPT_SAT_MAX = 16'sh7fff;
    localparam logic signed [15:0] HPT_SAT_MIN = -16'sh8000;
    localparam logic signed [15:0] HPT_ONE     = 16'sh0100;

    typedef logic signed [HPT_ACC_W-1:0] t_acc;

    // one item of row sums between front and back
    typedef struct packed {
        t_acc [3:0] acc;
        logic       last;
    } t_item;

    // one stage of the divide pipeline
    typedef struct packed {
        logic [HPT_MAG_W-1:0]           d;
        logic [2:0][HPT_NUM_W-1:0]      rem;
        logic [2:0][HPT_QBITS-1:0]      q;
        logic [2:0]                     neg;
        logic [2:0]                     ovf;
        logic                           wz;
        logic [3:0][15:0]               raw;
        logic                           last;
    } t_stage;

endpackage

// ----- hdl/hpt_front.sv -----
module hpt_front #(
    parameter int DEPTH = hpt_pkg::HPT_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [3:0][63:0]           i_rows,
    input  logic signed [3:0][15:0]    i_point,
    input  logic                       i_last,
    input  logic [$clog2(DEPTH+1)-1:0] i_fifo_count,
    output logic                       o_push,
    output hpt_pkg::t_item             o_item
);

    logic                     r_va, r_vb;
    logic signed [31:0]       r_prod [4][4];
    logic                     r_last_a;
    hpt_pkg::t_item           r_item;
    logic [$clog2(DEPTH+1):0] w_used;

    // credit check: queue plus items in flight must leave a free slot
    assign w_used  = {1'b0, i_fifo_count} + ($clog2(DEPTH+1)+1)'(r_va)
                   + ($clog2(DEPTH+1)+1)'(r_vb);
    assign o_ready = w_used < ($clog2(DEPTH+1)+1)'(DEPTH);

    // valid bits of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid && o_ready;
            r_vb <= r_va;
        end
    end

    // element products
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[r][c] <= $signed(i_rows[r][16*c +: 16]) * $signed(i_point[c]);
            end
        end
        r_last_a <= i_last;
    end

    // row sums
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            r_item.acc[r] <= hpt_pkg::HPT_ACC_W'(r_prod[r][0]) + hpt_pkg::HPT_ACC_W'(r_prod[r][1])
                           + hpt_pkg::HPT_ACC_W'(r_prod[r][2]) + hpt_pkg::HPT_ACC_W'(r_prod[r][3]);
        end
        r_item.last <= r_last_a;
    end

    assign o_push = r_vb;
    assign o_item = r_item;

endmodule

// ----- hdl/hpt_fifo.sv -----
`include "homogeneous_point_transform_assert.svh"

module hpt_fifo #(
    parameter int DEPTH = hpt_pkg::HPT_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  hpt_pkg::t_item             i_item,
    input  logic                       i_pop,
    output hpt_pkg::t_item             o_item,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hpt_pkg::t_item             r_mem [DEPTH];
    logic [PW-1:0]              r_wp, r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_count;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + ($clog2(DEPTH+1))'(i_push) - ($clog2(DEPTH+1))'(i_pop);
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_count = r_count;

    `HPT_ASSERT_NOW(a_no_overflow, i_push && !i_pop, r_count < ($clog2(DEPTH+1))'(DEPTH))
    `HPT_ASSERT_NOW(a_no_underflow, i_pop, r_count != '0)
    `HPT_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ----- hdl/hpt_back.sv -----
module hpt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  hpt_pkg::t_item       i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_x,
    output logic signed [15:0]   o_y,
    output logic signed [15:0]   o_z,
    output logic signed [15:0]   o_w,
    output logic                 o_wz,
    output logic                 o_last
);

    localparam int NS = hpt_pkg::HPT_QBITS;

    hpt_pkg::t_stage   r_stg [NS+1];
    hpt_pkg::t_stage   w_nxt [1:NS];
    logic [NS:0]       r_vld;
    hpt_pkg::t_stage   w_s0;
    logic              w_en;
    logic              r_valid;
    logic signed [15:0] r_x, r_y, r_z, r_w;
    logic              r_wz, r_last;
    logic signed [15:0] w_res [3];

    assign w_en  = !r_valid || i_ready;
    assign o_pop = w_en && i_avail;

    // raw value saturated, q.16 to q8.8 toward zero
    function automatic logic [15:0] raw_sat(input hpt_pkg::t_acc a);
        logic signed [hpt_pkg::HPT_ACC_W-1:0] t;
        t = (a < 0) ? ((a + 34'sd255) >>> 8) : (a >>> 8);
        if (t > hpt_pkg::HPT_ACC_W'(hpt_pkg::HPT_SAT_MAX)) begin
            return hpt_pkg::HPT_SAT_MAX;
        end else if (t < hpt_pkg::HPT_ACC_W'(hpt_pkg::HPT_SAT_MIN)) begin
            return hpt_pkg::HPT_SAT_MIN;
        end
        return t[15:0];
    endfunction

    // magnitude of an accumulator
    function automatic logic [hpt_pkg::HPT_MAG_W-1:0] mag(input hpt_pkg::t_acc a);
        hpt_pkg::t_acc t;
        t = (a < 0) ? -a : a;
        return t[hpt_pkg::HPT_MAG_W-1:0];
    endfunction

    // setup: signs, magnitudes, range check, raw results
    always_comb begin
        w_s0.d    = mag(i_item.acc[3]);
        w_s0.wz   = (i_item.acc[3] == '0);
        w_s0.last = i_item.last;
        for (int r = 0; r < 4; r++) begin
            w_s0.raw[r] = raw_sat(i_item.acc[r]);
        end
        for (int l = 0; l < 3; l++) begin
            w_s0.rem[l] = {mag(i_item.acc[l]), 8'b0};
            w_s0.q[l]   = '0;
            w_s0.neg[l] = i_item.acc[l][hpt_pkg::HPT_ACC_W-1] ^ i_item.acc[3][hpt_pkg::HPT_ACC_W-1];
            w_s0.ovf[l] = {9'b0, w_s0.rem[l]} >= ({17'b0, w_s0.d} << NS);
        end
    end

    // restoring divide, one quotient bit per stage
    always_comb begin
        for (int s = 1; s <= NS; s++) begin
            w_nxt[s] = r_stg[s-1];
            for (int l = 0; l < 3; l++) begin
                if ({9'b0, r_stg[s-1].rem[l]} >= ({17'b0, r_stg[s-1].d} << (NS - s))) begin
                    w_nxt[s].rem[l] = hpt_pkg::HPT_NUM_W'({9'b0, r_stg[s-1].rem[l]}
                                     - ({17'b0, r_stg[s-1].d} << (NS - s)));
                    w_nxt[s].q[l][NS-s] = 1'b1;
                end
            end
        end
    end

    // divide pipeline registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stg[0] <= w_s0;
            for (int s = 1; s <= NS; s++) begin
                r_stg[s] <= w_nxt[s];
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-1:0], o_pop};
        end
    end

    // sign and saturate the quotient, or pass the raw value when w is zero
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_stg[NS].wz) begin
                w_res[l] = r_stg[NS].raw[l];
            end else if (!r_stg[NS].neg[l]) begin
                w_res[l] = (r_stg[NS].ovf[l] || r_stg[NS].q[l] > NS'(32767))
                         ? hpt_pkg::HPT_SAT_MAX : r_stg[NS].q[l][15:0];
            end else begin
                w_res[l] = (r_stg[NS].ovf[l] || r_stg[NS].q[l] > NS'(32768))
                         ? hpt_pkg::HPT_SAT_MIN : 16'(-r_stg[NS].q[l]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x    <= w_res[0];
            r_y    <= w_res[1];
            r_z    <= w_res[2];
            r_w    <= r_stg[NS].wz ? r_stg[NS].raw[3] : hpt_pkg::HPT_ONE;
            r_wz   <= r_stg[NS].wz;
            r_last <= r_stg[NS].last;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_w     = r_w;
    assign o_wz    = r_wz;
    assign o_last  = r_last;

endmodule

// ----- hdl/homogeneous_point_transform.sv -----
// path from input transfer to result valid: product register, row-sum register, queue entry,
//   divide pipeline registers r_stg and output register
// throughput: one point per cycle when i_ready allows, set by the one-bit-per-stage divider
// reset: synchronous active low, clears valid bits, queue pointers and queue count only
module homogeneous_point_transform #(
    parameter int FIFO_DEPTH = hpt_pkg::HPT_FIFO_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_matrix_row0,
    input  logic [63:0]        i_matrix_row1,
    input  logic [63:0]        i_matrix_row2,
    input  logic [63:0]        i_matrix_row3,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_point_z,
    input  logic signed [15:0] i_point_w,
    input  logic               i_last_point,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic signed [15:0] o_out_w,
    output logic               o_w_was_zero,
    output logic               o_last_out
);

    logic                            w_push, w_pop;
    hpt_pkg::t_item                  w_fin, w_fout;
    logic [$clog2(FIFO_DEPTH+1)-1:0] w_count;

    // front: products and row sums
    hpt_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rows       ({i_matrix_row3, i_matrix_row2, i_matrix_row1, i_matrix_row0}),
        .i_point      ({i_point_w, i_point_z, i_point_y, i_point_x}),
        .i_last       (i_last_point),
        .i_fifo_count (w_count),
        .o_push       (w_push),
        .o_item       (w_fin)
    );

    // queue between front and back
    hpt_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fin),
        .i_pop   (w_pop),
        .o_item  (w_fout),
        .o_count (w_count)
    );

    // back: perspective divide and saturation
    hpt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_count != '0),
        .i_item  (w_fout),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z),
        .o_w     (o_out_w),
        .o_wz    (o_w_was_zero),
        .o_last  (o_last_out)
    );

endmodule
